// File: src/asc_pkg.sv
package asc_pkg;

	typedef logic [63:0] word_t;
	typedef word_t [4:0] sponge_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_PERM,
		ST_EMIT
	} st_t;

	// what the running permutation is for
	typedef enum logic [2:0] {
		JOB_INIT,
		JOB_AD,
		JOB_TEXT,
		JOB_FINAL,
		JOB_SQ0,
		JOB_SQ1,
		JOB_SQ2,
		JOB_SQ3
	} job_t;

	// message phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ASSOC,
		PH_TEXT
	} ph_t;

	// configuration register indexes
	localparam logic [2:0] REG_KEY_HI   = 3'd0;
	localparam logic [2:0] REG_KEY_LO   = 3'd1;
	localparam logic [2:0] REG_NONCE_HI = 3'd2;
	localparam logic [2:0] REG_NONCE_LO = 3'd3;
	localparam logic [2:0] REG_OP_MODE  = 3'd4;
	localparam logic [2:0] REG_SKIP_AD  = 3'd5;
	localparam logic [2:0] REG_TAG_HI   = 3'd6;
	localparam logic [2:0] REG_TAG_LO   = 3'd7;

	// op_mode codes
	localparam logic [1:0] MODE_ENC = 2'd0;
	localparam logic [1:0] MODE_DEC = 2'd1;

	// round schedule: round index runs up to LAST_ROUND
	localparam logic [3:0] LAST_ROUND  = 4'd11;
	localparam logic [3:0] START_INIT  = 4'd0;  // 12 rounds
	localparam logic [3:0] START_BLOCK = 4'd4;  // 8 rounds

	localparam word_t AEAD_IV = 64'h80800c0800000000;

	localparam sponge_t HASH_IV = '{
		64'ha13c42a223be8d87,
		64'hd6f6a54d7f52377d,
		64'h2ec8e3296c76384c,
		64'h738ec38ac0adffa7,
		64'h01470194fc6528a6
	};

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	// one round of the permutation with round index r
	function automatic sponge_t asc_round(input sponge_t s, input logic [3:0] r);
		sponge_t x;
		word_t   t0, t1, t2, t3, t4;
		x = s;
		// round constant
		x[2] = x[2] ^ {56'd0, 4'hf - r, r};
		// substitution layer
		x[0] = x[0] ^ x[4];
		x[4] = x[4] ^ x[3];
		x[2] = x[2] ^ x[1];
		t0 = ~x[0] & x[1];
		t1 = ~x[1] & x[2];
		t2 = ~x[2] & x[3];
		t3 = ~x[3] & x[4];
		t4 = ~x[4] & x[0];
		x[0] = x[0] ^ t1;
		x[1] = x[1] ^ t2;
		x[2] = x[2] ^ t3;
		x[3] = x[3] ^ t4;
		x[4] = x[4] ^ t0;
		x[1] = x[1] ^ x[0];
		x[0] = x[0] ^ x[4];
		x[3] = x[3] ^ x[2];
		x[2] = ~x[2];
		// linear diffusion
		x[0] = x[0] ^ rotr(x[0], 19) ^ rotr(x[0], 28);
		x[1] = x[1] ^ rotr(x[1], 61) ^ rotr(x[1], 39);
		x[2] = x[2] ^ rotr(x[2], 1) ^ rotr(x[2], 6);
		x[3] = x[3] ^ rotr(x[3], 10) ^ rotr(x[3], 17);
		x[4] = x[4] ^ rotr(x[4], 7) ^ rotr(x[4], 41);
		return x;
	endfunction

endpackage

// File: src/ascon_aead_and_hash_engine.sv
// sequence: an associated-data block or a middle hash block is accepted, absorbed and
// permuted with 8 rounds, a middle AEAD text block then also emits its result; the first
// block of an AEAD message adds 12 init rounds, the last AEAD text block takes 12 rounds
// and the last hash block 36 rounds before the emit; a full output register holds the emit.
// throughput: one item at a time, one permutation round per cycle in a single round unit.
// reset (arst_n low, asynchronous): idle, no message open, configuration registers zero.
module ascon_aead_and_hash_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  asc_pkg::word_t       cfg_data,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  asc_pkg::word_t       block_hi,
	input  asc_pkg::word_t       block_lo,
	input  logic                 block_last,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output asc_pkg::word_t       data_hi,
	output asc_pkg::word_t       data_lo,
	output logic                 msg_done,
	output logic                 tag_ok,
	output asc_pkg::word_t       digest_0,
	output asc_pkg::word_t       digest_1,
	output asc_pkg::word_t       digest_2,
	output asc_pkg::word_t       digest_3
);
	import asc_pkg::*;

	// configuration registers
	word_t      key_hi_q, key_lo_q, nonce_hi_q, nonce_lo_q, tag_hi_q, tag_lo_q;
	logic [1:0] op_mode_q;
	logic       skip_q;

	// sequencer and sponge
	st_t        st_q, st_d;
	job_t       job_q;
	ph_t        ph_q;
	logic [3:0] rnd_q;
	sponge_t    sp_q;
	sponge_t    rnd_out;

	// held item and partial results
	word_t      b0_q, b1_q;
	logic       last_q, aead_q, dec_q;
	word_t      txt_hi_q, txt_lo_q;
	word_t      dig0_q, dig1_q, dig2_q;

	// output register
	logic       out_valid_q;
	word_t      o_hi_q, o_lo_q, o_d0_q, o_d1_q, o_d2_q, o_d3_q;
	logic       o_done_q, o_ok_q;

	logic       emit_fire, perm_end, accept, item_aead;
	word_t      tag0, tag1, txt0, txt1;

	assign rnd_out   = asc_round(sp_q, rnd_q);
	assign perm_end  = (st_q == ST_PERM) && (rnd_q == LAST_ROUND);
	assign accept    = in_valid && in_ready;
	assign item_aead = ~op_mode_q[1];
	assign tag0      = sp_q[3] ^ key_hi_q;
	assign tag1      = sp_q[4] ^ key_lo_q;
	assign txt0      = sp_q[0] ^ b0_q;
	assign txt1      = sp_q[1] ^ b1_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_d = (ph_q == PH_IDLE && item_aead) ? ST_PERM : ST_PROC;
				end
			end
			ST_PROC: st_d = ST_PERM;
			ST_PERM: begin
				if (rnd_q == LAST_ROUND) begin
					case (job_q)
						JOB_INIT:  st_d = ST_PROC;
						JOB_AD:    st_d = ST_IDLE;
						JOB_TEXT:  st_d = aead_q ? ST_EMIT : ST_IDLE;
						JOB_FINAL: st_d = ST_EMIT;
						JOB_SQ3:   st_d = ST_EMIT;
						default:   st_d = ST_PERM;
					endcase
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (st_q == ST_IDLE);
		emit_fire = (st_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q   <= '0;
			key_lo_q   <= '0;
			nonce_hi_q <= '0;
			nonce_lo_q <= '0;
			op_mode_q  <= '0;
			skip_q     <= 1'b0;
			tag_hi_q   <= '0;
			tag_lo_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY_HI:   key_hi_q   <= cfg_data;
				REG_KEY_LO:   key_lo_q   <= cfg_data;
				REG_NONCE_HI: nonce_hi_q <= cfg_data;
				REG_NONCE_LO: nonce_lo_q <= cfg_data;
				REG_OP_MODE:  op_mode_q  <= cfg_data[1:0];
				REG_SKIP_AD:  skip_q     <= cfg_data[0];
				REG_TAG_HI:   tag_hi_q   <= cfg_data;
				REG_TAG_LO:   tag_lo_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// control state of the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			job_q  <= JOB_INIT;
			rnd_q  <= '0;
			aead_q <= 1'b1;
			dec_q  <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= block_last;
						aead_q <= item_aead;
						dec_q  <= (op_mode_q == MODE_DEC);
						if (ph_q == PH_IDLE) begin
							if (item_aead) begin
								rnd_q <= START_INIT;
								job_q <= JOB_INIT;
							end else begin
								ph_q <= PH_TEXT;
							end
						end
					end
				end
				ST_PROC: begin
					if (ph_q == PH_ASSOC) begin
						rnd_q <= START_BLOCK;
						job_q <= JOB_AD;
					end else if (!last_q) begin
						rnd_q <= START_BLOCK;
						job_q <= JOB_TEXT;
					end else begin
						ph_q  <= PH_IDLE;
						rnd_q <= START_INIT;
						job_q <= aead_q ? JOB_FINAL : JOB_SQ0;
					end
				end
				ST_PERM: begin
					if (rnd_q != LAST_ROUND) begin
						rnd_q <= rnd_q + 4'd1;
					end else begin
						case (job_q)
							JOB_INIT: ph_q <= skip_q ? PH_TEXT : PH_ASSOC;
							JOB_AD:   if (last_q) ph_q <= PH_TEXT;
							JOB_SQ0: begin
								rnd_q <= START_BLOCK;
								job_q <= JOB_SQ1;
							end
							JOB_SQ1: begin
								rnd_q <= START_BLOCK;
								job_q <= JOB_SQ2;
							end
							JOB_SQ2: begin
								rnd_q <= START_BLOCK;
								job_q <= JOB_SQ3;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// sponge datapath and held item
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					b0_q <= block_hi;
					b1_q <= block_lo;
					if (ph_q == PH_IDLE) begin
						if (item_aead) begin
							sp_q <= '{nonce_lo_q, nonce_hi_q, key_lo_q, key_hi_q, AEAD_IV};
						end else begin
							sp_q <= HASH_IV;
						end
					end
				end
			end
			ST_PROC: begin
				if (ph_q == PH_ASSOC) begin
					sp_q[0] <= txt0;
					sp_q[1] <= txt1;
				end else begin
					txt_hi_q <= txt0;
					txt_lo_q <= txt1;
					sp_q[0]  <= dec_q ? b0_q : txt0;
					sp_q[1]  <= dec_q ? b1_q : txt1;
					if (last_q && aead_q) begin
						sp_q[2] <= sp_q[2] ^ key_hi_q;
						sp_q[3] <= sp_q[3] ^ key_lo_q;
					end
				end
			end
			ST_PERM: begin
				// key into capacity after init, domain bit after last AD block or skipped AD
				if (perm_end && job_q == JOB_INIT) begin
					sp_q <= {rnd_out[4] ^ key_lo_q ^ {63'd0, skip_q},
						rnd_out[3] ^ key_hi_q, rnd_out[2:0]};
				end else if (perm_end && job_q == JOB_AD) begin
					sp_q <= {rnd_out[4] ^ {63'd0, last_q}, rnd_out[3:0]};
				end else begin
					sp_q <= rnd_out;
				end
				if (perm_end) begin
					case (job_q)
						JOB_SQ0:  dig0_q  <= rnd_out[0];
						JOB_SQ1:  dig1_q  <= rnd_out[0];
						JOB_SQ2:  dig2_q  <= rnd_out[0];
						default:  ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			o_hi_q   <= aead_q ? txt_hi_q : '0;
			o_lo_q   <= aead_q ? txt_lo_q : '0;
			o_done_q <= last_q;
			if (!last_q) begin
				o_ok_q <= 1'b0;
				o_d0_q <= '0;
				o_d1_q <= '0;
				o_d2_q <= '0;
				o_d3_q <= '0;
			end else if (aead_q) begin
				o_ok_q <= dec_q ? (tag0 == tag_hi_q && tag1 == tag_lo_q) : 1'b1;
				o_d0_q <= tag0;
				o_d1_q <= tag1;
				o_d2_q <= '0;
				o_d3_q <= '0;
			end else begin
				o_ok_q <= 1'b1;
				o_d0_q <= dig0_q;
				o_d1_q <= dig1_q;
				o_d2_q <= dig2_q;
				o_d3_q <= sp_q[0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign data_hi   = o_hi_q;
	assign data_lo   = o_lo_q;
	assign msg_done  = o_done_q;
	assign tag_ok    = o_ok_q;
	assign digest_0  = o_d0_q;
	assign digest_1  = o_d1_q;
	assign digest_2  = o_d2_q;
	assign digest_3  = o_d3_q;

	// round counter never runs past the last round
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_PERM |-> rnd_q <= LAST_ROUND)
		else $error("round index out of range");

	// an emitted item always shows up on the output
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> out_valid_q)
		else $error("emitted item not visible");

	// the later squeeze rounds (SQ1 to SQ3) only run in hash mode
	a_squeeze_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PERM && (job_q == JOB_SQ1 || job_q == JOB_SQ2 || job_q == JOB_SQ3))
		|-> !aead_q)
		else $error("squeeze in aead mode");

	// finishing the init permutation opens the message
	a_init_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(perm_end && job_q == JOB_INIT) |=> (ph_q == PH_ASSOC || ph_q == PH_TEXT))
		else $error("message not opened after init");

endmodule
